>>> src/rgba_pixel_dimmer_unit_defines.svh
// assertion macros shared by the pixel dimmer rtl
`ifndef RGBA_PIXEL_DIMMER_UNIT_DEFINES_SVH
`define RGBA_PIXEL_DIMMER_UNIT_DEFINES_SVH

// check that is held off while reset is asserted
`define RPD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that holds on every edge, reset included
`define RPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/rpd_pkg.sv
// types and constants shared by the pixel dimmer modules
package rpd_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_DESAT  = 2'd0;
  localparam logic [1:0] REG_OFFSET = 2'd1;
  localparam logic [1:0] REG_GAIN   = 2'd2;

  localparam logic [8:0]  FULL_WEIGHT = 9'd256;
  localparam logic [15:0] GAIN_RESET  = 16'd256;
  // floor(n / 3) == (n * 683) >> 11 for every n below 2048
  localparam logic [9:0]  RECIP_3     = 10'd683;

  // live settings seen by the datapath
  typedef struct packed {
    logic [8:0]        desat;   // already limited to 0..256
    logic signed [8:0] offset;
    logic [15:0]       gain;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pix_t;

  // after the channel sum and alpha product
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [9:0]  sum;
    logic [23:0] alpha_prod;
  } s1_t;

  // after gray and alpha saturation
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] gray;
    logic [7:0] alpha;
  } s2_t;

endpackage

>>> src/rpd_cfg.sv
// configuration registers of the pixel dimmer
module rpd_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output rpd_pkg::cfg_t       cfg_o
);

  logic [8:0]  desat_r;
  logic [8:0]  offset_r;
  logic [15:0] gain_r;

  assign cfg_ready = 1'b1;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desat_r  <= '0;
      offset_r <= '0;
      gain_r   <= rpd_pkg::GAIN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        rpd_pkg::REG_DESAT:  desat_r  <= cfg_data[8:0];
        rpd_pkg::REG_OFFSET: offset_r <= cfg_data[8:0];
        rpd_pkg::REG_GAIN:   gain_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // weight above full saturates to full gray
  always_comb begin
    cfg_o.desat  = (desat_r > rpd_pkg::FULL_WEIGHT) ? rpd_pkg::FULL_WEIGHT : desat_r;
    cfg_o.offset = $signed(offset_r);
    cfg_o.gain   = gain_r;
  end

endmodule

>>> src/rpd_gray.sv
// first two stages: channel sum, gray by reciprocal, alpha scale
module rpd_gray (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  rpd_pkg::cfg_t   cfg_i,
  input  logic            valid_i,
  input  rpd_pkg::pix_t   pix_i,
  output logic            valid1_o,
  output logic            valid_o,
  output rpd_pkg::s2_t    s2_o
);

  logic          v1_r;
  logic          v2_r;
  rpd_pkg::s1_t  s1_r;
  rpd_pkg::s1_t  s1_nxt;
  rpd_pkg::s2_t  s2_r;
  rpd_pkg::s2_t  s2_nxt;
  logic [19:0]   gray_prod;

  // stage one: sum of colours and raw alpha product
  always_comb begin
    s1_nxt.red        = pix_i.red;
    s1_nxt.green      = pix_i.green;
    s1_nxt.blue       = pix_i.blue;
    s1_nxt.sum        = {2'b00, pix_i.red} + {2'b00, pix_i.green} + {2'b00, pix_i.blue};
    s1_nxt.alpha_prod = {16'd0, pix_i.alpha} * {8'd0, cfg_i.gain};
  end

  // stage two: divide by three and saturate alpha
  always_comb begin
    gray_prod     = {10'd0, s1_r.sum} * {10'd0, rpd_pkg::RECIP_3};
    s2_nxt.red    = s1_r.red;
    s2_nxt.green  = s1_r.green;
    s2_nxt.blue   = s1_r.blue;
    s2_nxt.gray   = gray_prod[18:11];
    s2_nxt.alpha  = (|s1_r.alpha_prod[23:16]) ? 8'hFF : s1_r.alpha_prod[15:8];
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_i;
      v2_r <= v1_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
    end
  end

  assign valid1_o = v1_r;
  assign valid_o  = v2_r;
  assign s2_o     = s2_r;

endmodule

>>> src/rpd_blend.sv
// third stage: blend each colour toward gray
module rpd_blend (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  rpd_pkg::cfg_t   cfg_i,
  input  logic            valid_i,
  input  rpd_pkg::s2_t    s2_i,
  output logic            valid_o,
  output rpd_pkg::pix_t   pix_o
);

  logic           v_r;
  rpd_pkg::pix_t  pix_r;
  rpd_pkg::pix_t  pix_nxt;
  logic [8:0]     keep_w;
  logic [16:0]    gray_part;
  logic [16:0]    red_mix;
  logic [16:0]    green_mix;
  logic [16:0]    blue_mix;

  // c*(256-d) + gray*d, then drop eight fraction bits
  always_comb begin
    keep_w    = rpd_pkg::FULL_WEIGHT - cfg_i.desat;
    gray_part = {9'd0, s2_i.gray} * {8'd0, cfg_i.desat};
    red_mix   = ({9'd0, s2_i.red} * {8'd0, keep_w}) + gray_part;
    green_mix = ({9'd0, s2_i.green} * {8'd0, keep_w}) + gray_part;
    blue_mix  = ({9'd0, s2_i.blue} * {8'd0, keep_w}) + gray_part;
    pix_nxt.red   = red_mix[15:8];
    pix_nxt.green = green_mix[15:8];
    pix_nxt.blue  = blue_mix[15:8];
    pix_nxt.alpha = s2_i.alpha;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r <= pix_nxt;
    end
  end

  assign valid_o = v_r;
  assign pix_o   = pix_r;

endmodule

>>> src/rpd_offset.sv
// last stage: signed offset with clamp into the output register
module rpd_offset (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  rpd_pkg::cfg_t   cfg_i,
  input  logic            valid_i,
  input  rpd_pkg::pix_t   pix_i,
  output logic            valid_o,
  output rpd_pkg::pix_t   pix_o
);

  logic           v_r;
  rpd_pkg::pix_t  pix_r;
  rpd_pkg::pix_t  pix_nxt;

  function automatic logic [7:0] add_clamp(input logic [7:0] c, input logic signed [8:0] off);
    logic signed [9:0] v;
    v = $signed({2'b00, c}) + {off[8], off};
    if (v < 10'sd0) begin
      add_clamp = 8'd0;
    end else if (v > 10'sd255) begin
      add_clamp = 8'hFF;
    end else begin
      add_clamp = v[7:0];
    end
  endfunction

  always_comb begin
    pix_nxt.red   = add_clamp(pix_i.red, cfg_i.offset);
    pix_nxt.green = add_clamp(pix_i.green, cfg_i.offset);
    pix_nxt.blue  = add_clamp(pix_i.blue, cfg_i.offset);
    pix_nxt.alpha = pix_i.alpha;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r <= pix_nxt;
    end
  end

  assign valid_o = v_r;
  assign pix_o   = pix_r;

endmodule

>>> src/rgba_pixel_dimmer_unit.sv
// top level of the rgba pixel dimmer stream block
// The block takes one RGBA pixel per clock while in_tready is high and returns
// the dimmed pixel through four register stages: sum and alpha product, gray by
// reciprocal multiply with alpha saturation, blend toward gray, then offset with
// clamp into the output register. All four stages move together under one
// enable, so a stall on the output side holds every stage and in_tready falls in
// the same cycle; with out_tready high the block sustains one pixel per clock.
// Settings are taken from the configuration port and should only change while no
// pixel is in flight.
`include "rgba_pixel_dimmer_unit_defines.svh"

module rgba_pixel_dimmer_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // red_in, green_in, blue_in, alpha_in
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,  // red_out, green_out, blue_out, alpha_out
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  rpd_pkg::cfg_t cfg;
  rpd_pkg::pix_t in_pix;
  rpd_pkg::s2_t  s2;
  rpd_pkg::pix_t s3;
  rpd_pkg::pix_t res;
  logic          en;
  logic          v1;
  logic          v2;
  logic          v3;

  // whole pipe advances when the output register is free or being taken
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // unpack input beat
  always_comb begin
    in_pix.red   = in_tdata[7:0];
    in_pix.green = in_tdata[15:8];
    in_pix.blue  = in_tdata[23:16];
    in_pix.alpha = in_tdata[31:24];
  end

  rpd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  rpd_gray u_gray (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .cfg_i    (cfg),
    .valid_i  (in_tvalid),
    .pix_i    (in_pix),
    .valid1_o (v1),
    .valid_o  (v2),
    .s2_o     (s2)
  );

  rpd_blend u_blend (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .cfg_i   (cfg),
    .valid_i (v2),
    .s2_i    (s2),
    .valid_o (v3),
    .pix_o   (s3)
  );

  rpd_offset u_offset (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .cfg_i   (cfg),
    .valid_i (v3),
    .pix_i   (s3),
    .valid_o (out_tvalid),
    .pix_o   (res)
  );

  // pack output beat
  assign out_tdata = {res.alpha, res.blue, res.green, res.red};

  // checks
  `RPD_ASSERT(a_stall_blocks_input, (out_tvalid && !out_tready) |-> !in_tready, "input taken during output stall")
  `RPD_ASSERT_RST(a_desat_limited, cfg.desat <= rpd_pkg::FULL_WEIGHT, "blend weight above full")
  `RPD_ASSERT_RST(a_out_from_stage3, $rose(out_tvalid) |-> $past(v3), "result without a blended pixel")
  `RPD_ASSERT_RST(a_stage2_from_stage1, $rose(v2) |-> $past(v1), "gray stage valid without sum stage")

endmodule
